>>> rtl/tlbw_pkg.sv
`default_nettype none
package tlbw_pkg;

    // fixed field widths
    localparam int SLOT_BITS   = 7;
    localparam int CORNER_BITS = 6;
    localparam int WEIGHT_BITS = 16;
    localparam int COUNT_BITS  = 8;
    localparam int TRI_BITS    = 3 * CORNER_BITS;
    localparam int INDEX_BITS  = 7;
    localparam int STEP_BITS   = 4;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_SAT = '1;

    // request codes
    localparam logic [1:0] REQ_VERTEX = 2'd0;
    localparam logic [1:0] REQ_TRI    = 2'd1;
    localparam logic [1:0] REQ_QUERY  = 2'd2;

    // corner / weight selectors
    localparam logic [1:0] SEL_0 = 2'd0;
    localparam logic [1:0] SEL_1 = 2'd1;
    localparam logic [1:0] SEL_2 = 2'd2;

    typedef enum logic [1:0] {
        XOP_PAB,
        XOP_PBC,
        XOP_PCA,
        XOP_ABC
    } xop_t;

    typedef enum logic [1:0] {
        VSEL_A_RAW,
        VSEL_B,
        VSEL_C
    } vsel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRI_RD,
        ST_A_RD,
        ST_B_RD,
        ST_C_RD,
        ST_C_LAT,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SUB3,
        ST_TEST,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       wr_accept;
        logic       query_start;
        logic       idx_clr;
        logic       idx_inc;
        vsel_t      vsel;
        logic       lat_tri;
        logic       lat_a;
        logic       lat_b;
        logic       lat_c;
        logic       mul_en;
        xop_t       mul_op;
        logic       div_start;
        logic [1:0] div_sel;
        logic       res_load;
        logic       res_found;
    } cmd_t;

    typedef struct packed {
        logic edge_ok;
        logic last;
        logic cnt_zero;
        logic degenerate;
        logic div_done;
    } stat_t;

endpackage
`default_nettype wire

>>> rtl/tlbw_ram.sv
`default_nettype none
module tlbw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                     wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one write, one registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/tlbw_dp.sv
`default_nettype none
module tlbw_dp #(
    parameter int MAX_VERTICES  = 64,
    parameter int MAX_TRIANGLES = 128,
    parameter int COORD_BITS    = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire tlbw_pkg::cmd_t                         cmd,
    output tlbw_pkg::stat_t                             stat,
    input  wire logic [1:0]                             req_type,
    input  wire logic [tlbw_pkg::SLOT_BITS-1:0]         slot,
    input  wire logic signed [COORD_BITS-1:0]           coord_x,
    input  wire logic signed [COORD_BITS-1:0]           coord_y,
    input  wire logic [tlbw_pkg::CORNER_BITS-1:0]       corner_a,
    input  wire logic [tlbw_pkg::CORNER_BITS-1:0]       corner_b,
    input  wire logic [tlbw_pkg::CORNER_BITS-1:0]       corner_c,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [tlbw_pkg::COUNT_BITS-1:0]        cfg_wr_data,
    output logic                                        found,
    output logic                                        degenerate,
    output logic [tlbw_pkg::INDEX_BITS-1:0]             triangle_index,
    output logic [tlbw_pkg::CORNER_BITS-1:0]            vertex0,
    output logic [tlbw_pkg::CORNER_BITS-1:0]            vertex1,
    output logic [tlbw_pkg::CORNER_BITS-1:0]            vertex2,
    output logic [tlbw_pkg::WEIGHT_BITS-1:0]            weight0,
    output logic [tlbw_pkg::WEIGHT_BITS-1:0]            weight1,
    output logic [tlbw_pkg::WEIGHT_BITS-1:0]            weight2,
    output logic [1:0]                                  main_corner
);
    import tlbw_pkg::*;

    localparam int VW   = MAX_VERTICES > 1 ? $clog2(MAX_VERTICES) : 1;
    localparam int TW   = MAX_TRIANGLES > 1 ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CB   = COORD_BITS;
    localparam int DW   = CB + 1;
    localparam int PW   = 2 * DW;
    localparam int XW   = PW + 1;
    localparam int MW   = PW;
    localparam int RW   = MW + 1;
    localparam int LAST_STEP = WEIGHT_BITS - 1;

    // ---------------- configuration register ----------------
    logic [COUNT_BITS-1:0] tc_reg;
    logic [TW:0]           cnt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            tc_reg <= cfg_wr_data;
        end
    end

    assign cnt = (32'(tc_reg) > MAX_TRIANGLES) ? (TW+1)'(MAX_TRIANGLES) : (TW+1)'(tc_reg);

    // ---------------- tables ----------------
    logic                     v_we;
    logic                     t_we;
    logic [VW-1:0]            v_raddr;
    logic [2*CB-1:0]          v_rdata;
    logic [TRI_BITS-1:0]      t_rdata;
    logic [TW-1:0]            idx_reg;
    logic [TRI_BITS-1:0]      tri_reg;
    logic [CORNER_BITS-1:0]   v_corner;

    assign v_we = cmd.wr_accept && (req_type == REQ_VERTEX) && (32'(slot) < MAX_VERTICES);
    assign t_we = cmd.wr_accept && (req_type == REQ_TRI) && (32'(slot) < MAX_TRIANGLES);

    tlbw_ram #(.WIDTH(2 * CB), .DEPTH(MAX_VERTICES)) u_vram (
        .clk   (clk),
        .we    (v_we),
        .waddr (VW'(slot)),
        .wdata ({coord_y, coord_x}),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    tlbw_ram #(.WIDTH(TRI_BITS), .DEPTH(MAX_TRIANGLES)) u_tram (
        .clk   (clk),
        .we    (t_we),
        .waddr (TW'(slot)),
        .wdata ({corner_c, corner_b, corner_a}),
        .raddr (idx_reg),
        .rdata (t_rdata)
    );

    // corner address for the vertex read
    always_comb
    begin
        unique case (cmd.vsel)
            VSEL_A_RAW: v_corner = t_rdata[CORNER_BITS-1:0];
            VSEL_B:     v_corner = tri_reg[2*CORNER_BITS-1:CORNER_BITS];
            VSEL_C:     v_corner = tri_reg[3*CORNER_BITS-1:2*CORNER_BITS];
            default:    v_corner = tri_reg[CORNER_BITS-1:0];
        endcase
    end

    assign v_raddr = VW'(v_corner);

    // triangle index counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_clr || cmd.query_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign stat.last     = (32'(idx_reg) + 1) >= 32'(cnt);
    assign stat.cnt_zero = (cnt == '0);

    // ---------------- point and corner registers ----------------
    logic signed [CB-1:0] px_reg, py_reg;
    logic signed [CB-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic                 vok;
    logic [CORNER_BITS-1:0] lat_corner;
    logic signed [CB-1:0] vx, vy;

    always_comb
    begin
        if (cmd.lat_a)
        begin
            lat_corner = tri_reg[CORNER_BITS-1:0];
        end
        else if (cmd.lat_b)
        begin
            lat_corner = tri_reg[2*CORNER_BITS-1:CORNER_BITS];
        end
        else
        begin
            lat_corner = tri_reg[3*CORNER_BITS-1:2*CORNER_BITS];
        end
    end

    // out-of-range corners read as the origin
    assign vok = 32'(lat_corner) < MAX_VERTICES;
    assign vx  = vok ? v_rdata[CB-1:0] : '0;
    assign vy  = vok ? v_rdata[2*CB-1:CB] : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (cmd.lat_tri)
        begin
            tri_reg <= t_rdata;
        end
        if (cmd.lat_a)
        begin
            ax_reg <= vx;
            ay_reg <= vy;
        end
        if (cmd.lat_b)
        begin
            bx_reg <= vx;
            by_reg <= vy;
        end
        if (cmd.lat_c)
        begin
            cx_reg <= vx;
            cy_reg <= vy;
        end
    end

    // ---------------- cross product: multiply stage then subtract stage ----------------
    logic signed [CB-1:0] opx, opy, oqx, oqy, orx, ory;
    logic signed [PW-1:0] prod1_reg, prod2_reg;
    logic                 sub_en_reg;
    xop_t                 sub_op_reg;
    logic signed [XW-1:0] cr_pab_reg, cr_pbc_reg, cr_pca_reg, cr_abc_reg;
    logic signed [XW-1:0] cr_new;

    always_comb
    begin
        opx = px_reg;
        opy = py_reg;
        unique case (cmd.mul_op)
            XOP_PAB:
            begin
                oqx = ax_reg; oqy = ay_reg; orx = bx_reg; ory = by_reg;
            end
            XOP_PBC:
            begin
                oqx = bx_reg; oqy = by_reg; orx = cx_reg; ory = cy_reg;
            end
            XOP_PCA:
            begin
                oqx = cx_reg; oqy = cy_reg; orx = ax_reg; ory = ay_reg;
            end
            default:
            begin
                opx = ax_reg; opy = ay_reg;
                oqx = bx_reg; oqy = by_reg; orx = cx_reg; ory = cy_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod1_reg  <= (DW'(opx) - DW'(orx)) * (DW'(oqy) - DW'(ory));
        prod2_reg  <= (DW'(oqx) - DW'(orx)) * (DW'(opy) - DW'(ory));
        sub_op_reg <= cmd.mul_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_en_reg <= 1'b0;
        end
        else
        begin
            sub_en_reg <= cmd.mul_en;
        end
    end

    assign cr_new = XW'(prod1_reg) - XW'(prod2_reg);

    always_ff @(posedge clk)
    begin
        if (sub_en_reg)
        begin
            case (sub_op_reg)
                XOP_PAB: cr_pab_reg <= cr_new;
                XOP_PBC: cr_pbc_reg <= cr_new;
                XOP_PCA: cr_pca_reg <= cr_new;
                default: cr_abc_reg <= cr_new;
            endcase
        end
    end

    assign stat.edge_ok    = !cr_pab_reg[XW-1] && !cr_pbc_reg[XW-1] && !cr_pca_reg[XW-1];
    assign stat.degenerate = (cr_abc_reg == '0);

    // ---------------- bit-serial divider, one quotient bit a cycle ----------------
    logic signed [XW-1:0]   num_x;
    logic [MW-1:0]          num_m, den_m;
    logic [MW-1:0]          den_reg;
    logic [RW-1:0]          rem_reg, cand, rem_sub;
    logic [WEIGHT_BITS-1:0] q_reg;
    logic [STEP_BITS-1:0]   step_reg;
    logic                   busy_reg, sat_reg;
    logic [1:0]             sel_reg;
    logic                   ge;
    logic [WEIGHT_BITS-1:0] q_fin;
    logic [WEIGHT_BITS-1:0] w0_reg, w1_reg, w2_reg;

    always_comb
    begin
        case (cmd.div_sel)
            SEL_0:   num_x = cr_pbc_reg;
            SEL_1:   num_x = cr_pca_reg;
            default: num_x = cr_pab_reg;
        endcase
    end

    assign num_m = num_x[XW-1] ? MW'(-num_x) : MW'(num_x);
    assign den_m = cr_abc_reg[XW-1] ? MW'(-cr_abc_reg) : MW'(cr_abc_reg);

    assign cand    = (step_reg == '0) ? rem_reg : {rem_reg[RW-2:0], 1'b0};
    assign ge      = cand >= {1'b0, den_reg};
    assign rem_sub = cand - {1'b0, den_reg};
    assign q_fin   = {q_reg[WEIGHT_BITS-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_BITS'(LAST_STEP))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= {1'b0, num_m};
            den_reg <= den_m;
            sat_reg <= {1'b0, num_m} >= {den_m, 1'b0};
            sel_reg <= cmd.div_sel;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub : cand;
            q_reg   <= q_fin;
            if (step_reg == STEP_BITS'(LAST_STEP))
            begin
                case (sel_reg)
                    SEL_0:   w0_reg <= sat_reg ? WEIGHT_SAT : q_fin;
                    SEL_1:   w1_reg <= sat_reg ? WEIGHT_SAT : q_fin;
                    default: w2_reg <= sat_reg ? WEIGHT_SAT : q_fin;
                endcase
            end
        end
    end

    assign stat.div_done = !busy_reg;

    // ---------------- result register ----------------
    logic [WEIGHT_BITS-1:0] g0, g1, g2;
    logic [1:0]             mc;

    assign g0 = stat.degenerate ? '0 : w0_reg;
    assign g1 = stat.degenerate ? '0 : w1_reg;
    assign g2 = stat.degenerate ? '0 : w2_reg;

    // largest weight, ties to the lower corner
    always_comb
    begin
        if (g2 > ((g1 > g0) ? g1 : g0))
        begin
            mc = SEL_2;
        end
        else if (g1 > g0)
        begin
            mc = SEL_1;
        end
        else
        begin
            mc = SEL_0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            found          <= cmd.res_found;
            degenerate     <= stat.degenerate;
            triangle_index <= INDEX_BITS'(idx_reg);
            vertex0        <= tri_reg[CORNER_BITS-1:0];
            vertex1        <= tri_reg[2*CORNER_BITS-1:CORNER_BITS];
            vertex2        <= tri_reg[3*CORNER_BITS-1:2*CORNER_BITS];
            weight0        <= g0;
            weight1        <= g1;
            weight2        <= g2;
            main_corner    <= mc;
        end
    end

endmodule
`default_nettype wire

>>> rtl/tlbw_ctrl.sv
`default_nettype none
module tlbw_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [1:0]      req_type,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  wire tlbw_pkg::stat_t stat,
    output tlbw_pkg::cmd_t       cmd
);
    import tlbw_pkg::*;

    state_t     state_reg, state_next;
    logic       fallback_reg, fallback_next;
    logic [1:0] wsel_reg, wsel_next;
    logic       out_valid_reg, out_valid_next;
    logic       accept;
    logic       out_free;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign out_free = !(out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fallback_reg  <= 1'b0;
            wsel_reg      <= SEL_0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fallback_reg  <= fallback_next;
            wsel_reg      <= wsel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next    = state_reg;
        fallback_next = fallback_reg;
        wsel_next     = wsel_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_QUERY))
                begin
                    state_next    = ST_TRI_RD;
                    fallback_next = stat.cnt_zero;
                end
            end
            ST_TRI_RD: state_next = ST_A_RD;
            ST_A_RD:   state_next = ST_B_RD;
            ST_B_RD:   state_next = ST_C_RD;
            ST_C_RD:   state_next = ST_C_LAT;
            ST_C_LAT:  state_next = ST_MUL0;
            ST_MUL0:   state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_MUL3;
            ST_MUL3:   state_next = ST_SUB3;
            ST_SUB3:   state_next = ST_TEST;
            ST_TEST:
            begin
                if (fallback_reg || stat.edge_ok)
                begin
                    wsel_next  = SEL_0;
                    state_next = stat.degenerate ? ST_DONE : ST_DIV_START;
                end
                else if (stat.last)
                begin
                    fallback_next = 1'b1;
                    state_next    = ST_TRI_RD;
                end
                else
                begin
                    state_next = ST_TRI_RD;
                end
            end
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    if (wsel_reg == SEL_2)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        wsel_next  = wsel_reg + 1'b1;
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd             = '0;
        cmd.vsel        = VSEL_A_RAW;
        cmd.mul_op      = XOP_PAB;
        cmd.div_sel     = wsel_reg;
        cmd.res_found   = !fallback_reg;
        out_valid_next  = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.wr_accept   = accept;
                cmd.query_start = accept && (req_type == REQ_QUERY);
            end
            ST_A_RD:
            begin
                cmd.lat_tri = 1'b1;
                cmd.vsel    = VSEL_A_RAW;
            end
            ST_B_RD:
            begin
                cmd.lat_a = 1'b1;
                cmd.vsel  = VSEL_B;
            end
            ST_C_RD:
            begin
                cmd.lat_b = 1'b1;
                cmd.vsel  = VSEL_C;
            end
            ST_C_LAT: cmd.lat_c = 1'b1;
            ST_MUL0:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = XOP_PAB;
            end
            ST_MUL1:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = XOP_PBC;
            end
            ST_MUL2:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = XOP_PCA;
            end
            ST_MUL3:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = XOP_ABC;
            end
            ST_TEST:
            begin
                if (!(fallback_reg || stat.edge_ok))
                begin
                    cmd.idx_clr = stat.last;
                    cmd.idx_inc = !stat.last;
                end
            end
            ST_DIV_START: cmd.div_start = 1'b1;
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

>>> rtl/triangle_locate_barycentric_weights.sv
// Writes give no result; the next beat is taken the cycle after.
// A query searches the triangles in order (one table read and three vertex reads,
// then four cross products through two shared multipliers); if none matches,
// triangle 0 is used with found low; then three divisions (none for a zero-area triangle).
// One item at a time; a waiting result does not block the input side.
// rst_n clears the controller, triangle_count and the output valid; tables stay unset.
`default_nettype none
module triangle_locate_barycentric_weights #(
    parameter int MAX_VERTICES  = 64,
    parameter int MAX_TRIANGLES = 128,
    parameter int COORD_BITS    = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [1:0]                          req_type,
    input  wire logic [tlbw_pkg::SLOT_BITS-1:0]      slot,
    input  wire logic signed [COORD_BITS-1:0]        coord_x,
    input  wire logic signed [COORD_BITS-1:0]        coord_y,
    input  wire logic [tlbw_pkg::CORNER_BITS-1:0]    corner_a,
    input  wire logic [tlbw_pkg::CORNER_BITS-1:0]    corner_b,
    input  wire logic [tlbw_pkg::CORNER_BITS-1:0]    corner_c,
    input  wire logic                                cfg_wr_en,
    input  wire logic [tlbw_pkg::COUNT_BITS-1:0]     cfg_wr_data,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     found,
    output logic                                     degenerate,
    output logic [tlbw_pkg::INDEX_BITS-1:0]          triangle_index,
    output logic [tlbw_pkg::CORNER_BITS-1:0]         vertex0,
    output logic [tlbw_pkg::CORNER_BITS-1:0]         vertex1,
    output logic [tlbw_pkg::CORNER_BITS-1:0]         vertex2,
    output logic [tlbw_pkg::WEIGHT_BITS-1:0]         weight0,
    output logic [tlbw_pkg::WEIGHT_BITS-1:0]         weight1,
    output logic [tlbw_pkg::WEIGHT_BITS-1:0]         weight2,
    output logic [1:0]                               main_corner
);
    import tlbw_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tlbw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tlbw_dp #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .COORD_BITS    (COORD_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .slot           (slot),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .corner_a       (corner_a),
        .corner_b       (corner_b),
        .corner_c       (corner_c),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .found          (found),
        .degenerate     (degenerate),
        .triangle_index (triangle_index),
        .vertex0        (vertex0),
        .vertex1        (vertex1),
        .vertex2        (vertex2),
        .weight0        (weight0),
        .weight1        (weight1),
        .weight2        (weight2),
        .main_corner    (main_corner)
    );

endmodule
`default_nettype wire
